[src/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the scalar stress block
// widths of the tensor arithmetic, beat structs and the square-root cell data
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int GRAD_W   = 32;
	localparam int VISC_W   = 25;
	localparam int STRESS_W = 48;

	// scaled radicands after the viscosity multiply, one per output
	localparam int N_ROOTS  = 3;
	localparam int LANE_VM  = 0;
	localparam int LANE_INV = 1;
	localparam int LANE_DIF = 2;

	localparam int X_W     = 72;
	localparam int M2_W    = 2 * VISC_W;
	localparam int FULL_W  = X_W + M2_W;
	localparam int RAD_SH  = 32;
	localparam int RAD_W   = FULL_W - RAD_SH;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int N_CELLS = ROOT_W;

	typedef struct packed {
		logic signed [GRAD_W-1:0] du_dx;
		logic signed [GRAD_W-1:0] du_dy;
		logic signed [GRAD_W-1:0] du_dz;
		logic signed [GRAD_W-1:0] dv_dx;
		logic signed [GRAD_W-1:0] dv_dy;
		logic signed [GRAD_W-1:0] dv_dz;
		logic signed [GRAD_W-1:0] dw_dx;
		logic signed [GRAD_W-1:0] dw_dy;
		logic signed [GRAD_W-1:0] dw_dz;
		logic [VISC_W-1:0]        viscosity;
	} sts_grad_t;

	typedef struct packed {
		logic [STRESS_W-1:0] von_mises_stress;
		logic [STRESS_W-1:0] invariant_root_stress;
		logic [STRESS_W-1:0] difference_norm_stress;
	} sts_stress_t;

	typedef struct packed {
		logic [RAD_W-1:0]  x;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sts_lane_t;

	typedef struct packed {
		sts_lane_t [N_ROOTS-1:0] lane;
	} sts_root_t;

endpackage

[src/stress_tensor_scalar_stresses.sv]
// ----------------------------------------------------------------------------
// stress_tensor_scalar_stresses: scalar viscous stresses of one mesh cell
// tensor products, invariant and difference norm, viscosity scaling, roots
// ----------------------------------------------------------------------------
// One mesh cell is accepted per clock while the skid is empty; a result beat
// passes through the registered front stages of tensor products, sums and the
// viscosity multiply, then a chain of 45 square-root cells, one root bit per
// cell, then the output register. A one-beat skid behind the chain lets inputs
// keep flowing while a result waits; the input stalls only while the skid is
// full. The roots never exceed 45 bits, so the 48-bit outputs cannot saturate.
module stress_tensor_scalar_stresses (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 grad_valid,
	output logic                 grad_stall,
	input  sts_pkg::sts_grad_t   grad,
	output logic                 stress_valid,
	input  logic                 stress_stall,
	output sts_pkg::sts_stress_t stress
);
	import sts_pkg::*;

	localparam int N_PROD  = 9;
	localparam int MAG_W   = 35;
	localparam int LO_W    = 18;
	localparam int PP_W    = 2 * LO_W;
	localparam int PMAG_W  = 2 * MAG_W;
	localparam int PROD_W  = PMAG_W + 1;
	localparam int SUM_W   = PROD_W + 3;
	localparam int XL_W    = 24;
	localparam int N_XL    = X_W / XL_W;
	localparam int M2L_W   = VISC_W;
	localparam int N_ML    = M2_W / M2L_W;
	localparam int XP_W    = XL_W + M2L_W;
	localparam int ROW_W   = X_W + M2L_W;
	localparam int FRONT   = 9;
	localparam int N_STAGE = FRONT + N_CELLS;

	function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
		mag = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

	logic en;
	logic [N_STAGE-1:0] v_q;

	// tensor entries and diagonal differences
	logic signed [MAG_W-1:0] s11, s22, s33, s12, s13, s23, d12, d13, d23;
	logic signed [MAG_W-1:0] fa [N_PROD];
	logic signed [MAG_W-1:0] fb [N_PROD];

	logic [MAG_W-1:0]  am_s1 [N_PROD];
	logic [MAG_W-1:0]  bm_s1 [N_PROD];
	logic [N_PROD-1:0] neg_s1, neg_s2;
	logic [VISC_W-1:0] mu_s1;

	logic [PP_W-1:0] pp_s2 [N_PROD][4];
	logic [M2_W-1:0] m2_s2, m2_s3, m2_s4, m2_s5, m2_s6;

	logic [PMAG_W-1:0]        pm [N_PROD];
	logic signed [PROD_W-1:0] p_s3 [N_PROD];

	logic signed [SUM_W-1:0] cross_s4, off_s4, dsq_s4;
	logic signed [SUM_W-1:0] qv, bv;
	logic [SUM_W-1:0]        qabs_s5, bsum_s5;

	logic [X_W-1:0]  x_s6 [N_ROOTS];
	logic [XP_W-1:0] xp_s7 [N_ROOTS][N_XL][N_ML];
	logic [ROW_W-1:0] row [N_ROOTS][N_ML];
	logic [ROW_W-1:0] row_s8 [N_ROOTS][N_ML];
	logic [FULL_W-1:0] full [N_ROOTS];

	sts_root_t chain [N_CELLS+1];
	sts_root_t rad;

	sts_stress_t res, out_q, sk_q;
	logic        out_v_q, sk_v_q;

	assign en         = !sk_v_q;
	assign grad_stall = sk_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[N_STAGE-2:0], grad_valid};
		end
	end

	always_comb begin
		s11 = {{(MAG_W-GRAD_W-1){grad.du_dx[GRAD_W-1]}}, grad.du_dx, 1'b0};
		s22 = {{(MAG_W-GRAD_W-1){grad.dv_dy[GRAD_W-1]}}, grad.dv_dy, 1'b0};
		s33 = {{(MAG_W-GRAD_W-1){grad.dw_dz[GRAD_W-1]}}, grad.dw_dz, 1'b0};
		s12 = MAG_W'(grad.du_dy) + MAG_W'(grad.dv_dx);
		s13 = MAG_W'(grad.du_dz) + MAG_W'(grad.dw_dx);
		s23 = MAG_W'(grad.dv_dz) + MAG_W'(grad.dw_dy);
		d12 = s11 - s22;
		d13 = s11 - s33;
		d23 = s22 - s33;
		fa[0] = s11; fb[0] = s22;
		fa[1] = s11; fb[1] = s33;
		fa[2] = s22; fb[2] = s33;
		fa[3] = s12; fb[3] = s12;
		fa[4] = s13; fb[4] = s13;
		fa[5] = s23; fb[5] = s23;
		fa[6] = d12; fb[6] = d12;
		fa[7] = d13; fb[7] = d13;
		fa[8] = d23; fb[8] = d23;
	end

	// stage 1: factor magnitudes and product signs
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_PROD; i++) begin
				am_s1[i]  <= mag(fa[i]);
				bm_s1[i]  <= mag(fb[i]);
				neg_s1[i] <= fa[i][MAG_W-1] ^ fb[i][MAG_W-1];
			end
			mu_s1 <= grad.viscosity;
		end
	end

	// stage 2: partial products on 18-bit low and 17-bit high limbs, viscosity squared
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_PROD; i++) begin
				pp_s2[i][0] <= PP_W'(am_s1[i][LO_W-1:0] * bm_s1[i][LO_W-1:0]);
				pp_s2[i][1] <= PP_W'(am_s1[i][LO_W-1:0] * bm_s1[i][MAG_W-1:LO_W]);
				pp_s2[i][2] <= PP_W'(am_s1[i][MAG_W-1:LO_W] * bm_s1[i][LO_W-1:0]);
				pp_s2[i][3] <= PP_W'(am_s1[i][MAG_W-1:LO_W] * bm_s1[i][MAG_W-1:LO_W]);
			end
			neg_s2 <= neg_s1;
			m2_s2  <= M2_W'(mu_s1 * mu_s1);
		end
	end

	// stage 3: signed products
	always_comb begin
		for (int i = 0; i < N_PROD; i++) begin
			pm[i] = PMAG_W'(pp_s2[i][0])
				+ (PMAG_W'(pp_s2[i][1]) << LO_W)
				+ (PMAG_W'(pp_s2[i][2]) << LO_W)
				+ (PMAG_W'(pp_s2[i][3]) << (2 * LO_W));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_PROD; i++) begin
				p_s3[i] <= neg_s2[i] ? -$signed({1'b0, pm[i]}) : $signed({1'b0, pm[i]});
			end
			m2_s3 <= m2_s2;
		end
	end

	// stage 4: cross terms, off-diagonal squares, difference squares
	always_ff @(posedge clk) begin
		if (en) begin
			cross_s4 <= SUM_W'(p_s3[0]) + SUM_W'(p_s3[1]) + SUM_W'(p_s3[2]);
			off_s4   <= SUM_W'(p_s3[3]) + SUM_W'(p_s3[4]) + SUM_W'(p_s3[5]);
			dsq_s4   <= SUM_W'(p_s3[6]) + SUM_W'(p_s3[7]) + SUM_W'(p_s3[8]);
			m2_s4    <= m2_s3;
		end
	end

	// stage 5: absolute invariant and difference norm squared
	always_comb begin
		qv = cross_s4 - off_s4;
		bv = dsq_s4 + (off_s4 <<< 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qabs_s5 <= qv[SUM_W-1] ? SUM_W'(-qv) : SUM_W'(qv);
			bsum_s5 <= SUM_W'(bv);
			m2_s5   <= m2_s4;
		end
	end

	// stage 6: radicands before scaling
	always_ff @(posedge clk) begin
		if (en) begin
			x_s6[LANE_VM]  <= X_W'(qabs_s5 + (qabs_s5 << 1));
			x_s6[LANE_INV] <= X_W'(qabs_s5);
			x_s6[LANE_DIF] <= X_W'(bsum_s5);
			m2_s6          <= m2_s5;
		end
	end

	// stage 7: radicand times viscosity squared, limb partials
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < N_ROOTS; r++) begin
				for (int i = 0; i < N_XL; i++) begin
					for (int j = 0; j < N_ML; j++) begin
						xp_s7[r][i][j] <= XP_W'(x_s6[r][i*XL_W +: XL_W]
							* m2_s6[j*M2L_W +: M2L_W]);
					end
				end
			end
		end
	end

	// stage 8: one row per viscosity limb
	always_comb begin
		for (int r = 0; r < N_ROOTS; r++) begin
			for (int j = 0; j < N_ML; j++) begin
				row[r][j] = '0;
				for (int i = 0; i < N_XL; i++) begin
					row[r][j] = row[r][j] + (ROW_W'(xp_s7[r][i][j]) << (i * XL_W));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s8 <= row;
		end
	end

	// stage 9: full product, drop the 2^-32 fraction, seed the root chain
	always_comb begin
		for (int r = 0; r < N_ROOTS; r++) begin
			full[r] = FULL_W'(row_s8[r][0]);
			for (int j = 1; j < N_ML; j++) begin
				full[r] = full[r] + (FULL_W'(row_s8[r][j]) << (j * M2L_W));
			end
			rad.lane[r].x    = full[r][FULL_W-1:RAD_SH];
			rad.lane[r].rem  = '0;
			rad.lane[r].root = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chain[0] <= rad;
		end
	end

	for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
		sts_root_cell u_cell (
			.clk  (clk),
			.en   (en),
			.prev (chain[c]),
			.next (chain[c+1])
		);
	end

	always_comb begin
		res.von_mises_stress       = STRESS_W'(chain[N_CELLS].lane[LANE_VM].root);
		res.invariant_root_stress  = STRESS_W'(chain[N_CELLS].lane[LANE_INV].root);
		res.difference_norm_stress = STRESS_W'(chain[N_CELLS].lane[LANE_DIF].root);
	end

	// output register with one-beat skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (sk_v_q) begin
			if (!out_v_q || !stress_stall) begin
				out_v_q <= 1'b1;
				sk_v_q  <= 1'b0;
			end
		end else if (!out_v_q || !stress_stall) begin
			out_v_q <= v_q[N_STAGE-1];
		end else if (v_q[N_STAGE-1]) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (!out_v_q || !stress_stall) begin
				out_q <= sk_q;
			end
		end else if (!out_v_q || !stress_stall) begin
			out_q <= res;
		end else begin
			sk_q <= res;
		end
	end

	assign stress_valid = out_v_q;
	assign stress       = out_q;

	// a finished beat leaving the chain lands in the output or the skid
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[N_STAGE-1] && !sk_v_q) |=> (stress_valid || sk_v_q))
		else $error("result beat lost at chain end");

	// skid only fills behind a held output
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> stress_valid)
		else $error("skid holds a beat with output empty");

	// a taken output drains the skid
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(sk_v_q && !stress_stall) |=> !sk_v_q)
		else $error("skid not drained");

endmodule

[src/sts_root_cell.sv]
// ----------------------------------------------------------------------------
// sts_root_cell: one digit step of the square-root chain
// takes two radicand bits per lane and settles one root bit, then registers
// ----------------------------------------------------------------------------
module sts_root_cell (
	input  logic             clk,
	input  logic             en,
	input  sts_pkg::sts_root_t prev,
	output sts_pkg::sts_root_t next
);
	import sts_pkg::*;

	sts_root_t next_q;
	sts_root_t step;
	logic [REM_W+1:0] rem_sh [N_ROOTS];
	logic [REM_W+1:0] trial  [N_ROOTS];

	always_comb begin
		for (int k = 0; k < N_ROOTS; k++) begin
			rem_sh[k] = {prev.lane[k].rem, prev.lane[k].x[RAD_W-1 -: 2]};
			trial[k]  = (REM_W+2)'({prev.lane[k].root, 2'b01});
			step.lane[k].x = {prev.lane[k].x[RAD_W-3:0], 2'b00};
			if (rem_sh[k] >= trial[k]) begin
				step.lane[k].rem  = REM_W'(rem_sh[k] - trial[k]);
				step.lane[k].root = {prev.lane[k].root[ROOT_W-2:0], 1'b1};
			end else begin
				step.lane[k].rem  = REM_W'(rem_sh[k]);
				step.lane[k].root = {prev.lane[k].root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			next_q <= step;
		end
	end

	assign next = next_q;

endmodule
